// ===== rtl/lra_pkg.sv =====
package lra_pkg;

   // Coordinate width used when the top level is not overridden
   localparam int CoordBits = 12;

   // Request kinds carried on the action field
   typedef enum logic {
      ACTION_LOAD = 1'b0,
      ACTION_STEP = 1'b1
   } action_type;

endpackage

// ===== rtl/line_rasterizer_unit.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    action, x_start, y_start, x_end, y_end
// rsp      out        rsp_valid/rsp_ready    pixel_x, pixel_y, last_pixel
//
// One request per cycle unless a held result stalls it; a step with a line active
// puts its pixel into the result register at the same edge that takes it.
// The line state and the result register set the pace; the error update is one
// add and one compare/correct per step.
// Reset (synchronous, active high) drops any line in progress and the result.
// A held result blocks new requests only while rsp_ready stays low.
module line_rasterizer_unit #(
   parameter int COORD_BITS = lra_pkg::CoordBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last_pixel
);

   localparam int C  = COORD_BITS;
   localparam int SW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;

   // Line state
   logic                 line_active_ff, line_active_in;
   logic                 x_is_major_ff, x_is_major_in;
   logic signed [C-1:0]  major_pos_ff, major_pos_in;
   logic signed [C-1:0]  major_stop_ff, major_stop_in;
   logic signed [C-1:0]  minor_pos_ff, minor_pos_in;
   logic signed [SW-1:0] major_span_ff, major_span_in;
   logic signed [SW-1:0] minor_span_ff, minor_span_in;
   logic signed [EW-1:0] round_err_ff, round_err_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0]  pixel_x_ff, pixel_x_in;
   logic signed [C-1:0]  pixel_y_ff, pixel_y_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 is_step;
   logic                 emit;
   logic                 at_last;

   // Load setup
   logic signed [SW-1:0] dx, dy;
   logic [SW-1:0]        adx, ady;
   logic                 load_x_major;
   logic signed [C-1:0]  ma, na, mb, nb;
   logic                 swap;
   logic signed [C-1:0]  start_major, start_minor, stop_major, stop_minor;

   // Step datapath
   logic signed [EW-1:0] span_ext;
   logic signed [EW-1:0] twice_err;
   logic                 round_up;
   logic signed [C-1:0]  minor_out;
   logic signed [EW-1:0] err_sum;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_step   = lra_pkg::action_type'(req_action) == lra_pkg::ACTION_STEP;
   assign emit      = accept && is_step && line_active_ff;
   assign at_last   = major_pos_ff == major_stop_ff;

   // Pick the major axis and order the endpoints along it
   always_comb begin
      dx = SW'(req_x_end) - SW'(req_x_start);
      dy = SW'(req_y_end) - SW'(req_y_start);
      adx = dx[SW-1] ? $unsigned(-dx) : $unsigned(dx);
      ady = dy[SW-1] ? $unsigned(-dy) : $unsigned(dy);
      load_x_major = adx >= ady;
      if (load_x_major) begin
         ma = req_x_start;
         na = req_y_start;
         mb = req_x_end;
         nb = req_y_end;
      end else begin
         ma = req_y_start;
         na = req_x_start;
         mb = req_y_end;
         nb = req_x_end;
      end
      swap        = mb < ma;
      start_major = swap ? mb : ma;
      start_minor = swap ? nb : na;
      stop_major  = swap ? ma : mb;
      stop_minor  = swap ? na : nb;
   end

   // Round the minor coordinate half away from zero
   always_comb begin
      span_ext  = EW'(major_span_ff);
      twice_err = round_err_ff <<< 1;
      if (major_span_ff == '0) begin
         round_up = 1'b0;
      end else if (!minor_pos_ff[C-1]) begin
         round_up = twice_err >= span_ext;
      end else begin
         round_up = twice_err > span_ext;
      end
      minor_out = round_up ? minor_pos_ff + C'(1) : minor_pos_ff;
      err_sum   = round_err_ff + EW'(minor_span_ff);
   end

   // Next line state
   always_comb begin
      line_active_in = line_active_ff;
      x_is_major_in  = x_is_major_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      minor_pos_in   = minor_pos_ff;
      major_span_in  = major_span_ff;
      minor_span_in  = minor_span_ff;
      round_err_in   = round_err_ff;
      if (accept && !is_step) begin
         line_active_in = 1'b1;
         x_is_major_in  = load_x_major;
         major_pos_in   = start_major;
         major_stop_in  = stop_major;
         minor_pos_in   = start_minor;
         major_span_in  = SW'(stop_major) - SW'(start_major);
         minor_span_in  = SW'(stop_minor) - SW'(start_minor);
         round_err_in   = '0;
      end else if (emit) begin
         if (at_last) begin
            line_active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + C'(1);
            if (err_sum >= span_ext) begin
               round_err_in = err_sum - span_ext;
               minor_pos_in = minor_pos_ff + C'(1);
            end else if (err_sum < 0) begin
               round_err_in = err_sum + span_ext;
               minor_pos_in = minor_pos_ff - C'(1);
            end else begin
               round_err_in = err_sum;
            end
         end
      end
   end

   // Load the result register on a step, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pixel_x_in   = pixel_x_ff;
      pixel_y_in   = pixel_y_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         pixel_x_in   = x_is_major_ff ? major_pos_ff : minor_out;
         pixel_y_in   = x_is_major_ff ? minor_out : major_pos_ff;
         last_in      = at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_is_major_ff <= x_is_major_in;
      major_pos_ff  <= major_pos_in;
      major_stop_ff <= major_stop_in;
      minor_pos_ff  <= minor_pos_in;
      major_span_ff <= major_span_in;
      minor_span_ff <= minor_span_in;
      round_err_ff  <= round_err_in;
      pixel_x_ff    <= pixel_x_in;
      pixel_y_ff    <= pixel_y_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = pixel_x_ff;
   assign rsp_pixel_y    = pixel_y_ff;
   assign rsp_last_pixel = last_ff;

`ifndef SYNTH
   // A new result appears only after a step on an active line
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result without an active step");

   // The final pixel ends the line
   assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> !line_active_ff)
      else $error("line still active after final pixel");

   // The walk never passes the stop coordinate
   assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> major_pos_ff <= major_stop_ff)
      else $error("major position beyond stop");

   // The remainder stays within one major span
   assert property (@(posedge clock) disable iff (reset)
      (line_active_ff && major_span_ff != '0) |->
         (round_err_ff >= 0 && round_err_ff < span_ext))
      else $error("rounding error out of range");
`endif

endmodule
